// ===== src/pulse_period_tachometer_unit_macros.svh =====
// Assertion macros shared by the tachometer RTL.
`ifndef PULSE_PERIOD_TACHOMETER_UNIT_MACROS_SVH
`define PULSE_PERIOD_TACHOMETER_UNIT_MACROS_SVH

// Check a property on every clock while out of reset.
`define PPT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PPT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define PPT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ppt_pkg.sv =====
// Types and constants of the pulse period tachometer.
`default_nettype none

package ppt_pkg;

  localparam int CHANNELS  = 4;
  localparam int TIME_BITS = 40;

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TIME_W   = TIME_BITS;
  localparam int SPEED_W  = 16;
  localparam int PPR_W    = 7;
  localparam int DT_W     = 26;
  localparam int QUOT_W   = 26;
  localparam int PROD_W   = DT_W + PPR_W;
  localparam int CNT_W    = $clog2(QUOT_W);
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [QUOT_W-1:0]  US_PER_MINUTE = 26'd60000000;
  localparam logic [PPR_W-1:0]   PPR_RESET     = 7'd1;
  localparam logic [SPEED_W-1:0] CEIL_RESET    = 16'd6000;

  localparam logic REG_PPR  = 1'b0;
  localparam logic REG_CEIL = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] time_us;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]    out_channel;
    logic [SPEED_W-1:0] speed_rpm;
    logic               speed_valid;
  } out_word_t;

  typedef struct packed {
    logic [PPR_W-1:0]   edges_per_turn;
    logic [SPEED_W-1:0] rpm_ceiling;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/ppt_regs.sv =====
// APB configuration registers of the tachometer.
`default_nettype none

module ppt_regs import ppt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [PPR_W-1:0]   ppr_q;
  logic [SPEED_W-1:0] ceil_q;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q  <= PPR_RESET;
      ceil_q <= CEIL_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PPR:  ppr_q  <= pwdata[PPR_W-1:0];
        REG_CEIL: ceil_q <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PPR:  prdata = APB_DW'(ppr_q);
      REG_CEIL: prdata = APB_DW'(ceil_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.edges_per_turn = ppr_q;
  assign cfg_o.rpm_ceiling    = ceil_q;

endmodule

`default_nettype wire

// ===== src/ppt_div.sv =====
// Bit-serial restoring divider of one minute in microseconds by period times PPR.
`default_nettype none

`include "pulse_period_tachometer_unit_macros.svh"

module ppt_div import ppt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] div_q;
  logic [PROD_W-1:0] rem_q;
  logic [QUOT_W-1:0] quot_q;
  logic [PROD_W:0]   rem_sh;
  logic [PROD_W:0]   trial;
  logic              ge;

  assign rem_sh = {rem_q, quot_q[QUOT_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign trial  = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(QUOT_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= US_PER_MINUTE;
    end else if (busy_q) begin
      rem_q  <= ge ? trial[PROD_W-1:0] : rem_sh[PROD_W-1:0];
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  `PPT_ASSERT_NXT(a_start_busy, start_i, busy_q, "divider did not start")
  `PPT_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q) && !busy_q, "done without busy")
  `PPT_ASSERT_IMP(a_cnt_range, busy_q, cnt_q < CNT_W'(QUOT_W), "step count overrun")
  `PPT_ASSERT_IMP(a_no_restart, busy_q, !start_i, "start while busy")

endmodule

`default_nettype wire

// ===== src/pulse_period_tachometer_unit.sv =====
// Top level of the multi-channel pulse period tachometer.
`default_nettype none

`include "pulse_period_tachometer_unit_macros.svh"

// Multi-channel tachometer: each input word is one pulse (channel, microsecond timestamp)
// and yields one output word with the channel, the speed in rpm and a flag that is low on
// a channel's first pulse or on a channel index outside the configured count. Speed is
// floor(60000000 / (dt * edges_per_turn)), saturated at rpm_ceiling; a zero interval or
// a zero edges_per_turn gives the ceiling. A word that needs a division goes from the
// accepting cycle through classify and multiply, 26 steps of the one-bit-per-cycle
// divider, quotient capture and output load to a valid output; other words skip the
// divider. The input is not ready while a word is in work; a finished word waits in the
// output register, so the next input can be taken while it is still pending.
module pulse_period_tachometer_unit import ppt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DT_EXT_W = (TIME_BITS > DT_W) ? TIME_BITS : DT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLASS = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  cfg_t cfg;

  logic [1:0]           state_q, state_d;
  logic [TIME_BITS-1:0] last_q [CHANNELS];
  logic [CHANNELS-1:0]  seen_q;
  logic [CH_W-1:0]      ch_q;
  logic [TIME_BITS-1:0] dt_q;
  logic                 prev_q;
  logic [SPEED_W-1:0]   speed_q, speed_d;
  logic                 valid_q, valid_d;
  logic                 out_valid_q;
  out_word_t            out_data_q;

  logic                 accept;
  logic                 ch_ok;
  logic [IDX_W-1:0]     idx;
  logic [TIME_BITS-1:0] now;
  logic [DT_EXT_W-1:0]  dt_ext;
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [QUOT_W-1:0]    quot;
  logic [PROD_W-1:0]    divisor;
  logic                 load_out;

  ppt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (divisor),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign ch_ok      = 32'(in_data_i.channel) < CHANNELS;
  assign idx        = IDX_W'(in_data_i.channel);
  assign now        = TIME_BITS'(in_data_i.time_us);
  assign dt_ext     = DT_EXT_W'(dt_q);
  assign divisor    = PROD_W'(dt_ext[DT_W-1:0]) * PROD_W'(cfg.edges_per_turn);
  assign load_out   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_q[i] <= '0;
      end
    end else if (accept && ch_ok) begin
      seen_q[idx] <= 1'b1;
      last_q[idx] <= now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= in_data_i.channel;
      dt_q   <= now - last_q[idx];
      prev_q <= ch_ok && seen_q[idx];
    end
  end

  always_comb begin
    state_d   = state_q;
    speed_d   = speed_q;
    valid_d   = valid_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: begin
        state_d = ST_FIN;
        valid_d = prev_q;
        if (!prev_q) begin
          speed_d = '0;
        end else if (dt_q == '0 || cfg.edges_per_turn == '0) begin
          speed_d = cfg.rpm_ceiling;
        end else if (dt_ext > DT_EXT_W'(US_PER_MINUTE)) begin
          speed_d = '0;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
          speed_d = (quot > QUOT_W'(cfg.rpm_ceiling)) ? cfg.rpm_ceiling : quot[SPEED_W-1:0];
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    speed_q <= speed_d;
    valid_q <= valid_d;
    if (load_out) begin
      out_data_q.out_channel <= ch_q;
      out_data_q.speed_rpm   <= speed_q;
      out_data_q.speed_valid <= valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `PPT_ASSERT_IMP(a_ready_div_idle, in_ready_o, !div_busy, "input ready during division")
  `PPT_ASSERT_IMP(a_first_zero, out_valid_o && !out_data_o.speed_valid,
                  out_data_o.speed_rpm == '0, "speed on a first pulse")
  `PPT_ASSERT_IMP(a_done_in_div, div_done, state_q == ST_DIV, "division result out of place")
  `PPT_ASSERT_NXT(a_accept_class, accept, state_q == ST_CLASS, "accepted word not classified")

endmodule

`default_nettype wire
